// File: sv/fifo_with_stack_snapshot_unit_macros.svh
// ----------------------------------------------------------------------------
// fifo_with_stack_snapshot_unit assertion macros
// shared property shapes; clk and rst_n come from the module that uses them
// ----------------------------------------------------------------------------
`ifndef FIFO_WITH_STACK_SNAPSHOT_UNIT_MACROS_SVH
`define FIFO_WITH_STACK_SNAPSHOT_UNIT_MACROS_SVH

// same-cycle implication
`define FSS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FSS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg
// shared constants and types of the fifo / stack snapshot unit
// ----------------------------------------------------------------------------
`default_nettype none

package fss_pkg;

  localparam int DEPTH  = 32;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int CMD_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_SHOW    = 2'd2,
    CMD_COPY    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CP_RD,
    ST_CP_WR,
    ST_SH_RD,
    ST_SH_LD
  } state_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } ram_ctl_t;

endpackage

`default_nettype wire

// File: sv/fifo_with_stack_snapshot_unit.sv
// ----------------------------------------------------------------------------
// fifo_with_stack_snapshot_unit
// circular word queue plus a stack snapshot of it, with a show stream
// ----------------------------------------------------------------------------
// usage:
//   commands come in on the in_ stream: in_tuser selects the command
//   (enqueue, dequeue, show stack, copy queue into stack), in_tdata carries
//   the word to enqueue. only show produces output: the stack is streamed
//   out on the out_ channel top entry first, out_tlast on the bottom entry.
// timing:
//   enqueue and dequeue leave in_tready high.
//   copy walks the queue words: each word is a queue ram read, addressed
//   through the shared index adder, followed by a stack ram write.
//   show walks the stack words: each word is a read of the stack ram,
//   whose read port is registered, then a load into the output register.
//   the registered stack ram read port sets the read-then-load step per word.
//   in_tready is low while a copy or show walks the memories.
// reset:
//   rst_n clears queue and stack fill counts, queue head and output valid;
//   ram contents are left as they are and are never read before written.
// stall:
//   a held output word waits in the output register; the show walk pauses
//   until it is taken, and a new command may be accepted behind the last.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fifo_with_stack_snapshot_unit_macros.svh"

module fifo_with_stack_snapshot_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [fss_pkg::WORD_W-1:0] in_tdata,   // [31:0] value
  input  logic [fss_pkg::CMD_W-1:0]  in_tuser,   // [1:0] cmd
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [fss_pkg::WORD_W-1:0] out_tdata,  // [31:0] word
  output logic                       out_tlast
);
  import fss_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [PTR_W-1:0]   qhead_r, qhead_nxt;
  logic [CNT_W-1:0]   qfill_r, qfill_nxt;
  logic [CNT_W-1:0]   sfill_r, sfill_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_word_r, out_word_nxt;
  logic               out_last_r, out_last_nxt;

  cmd_t               cmd;
  logic               in_fire;
  logic               q_full;
  logic               q_empty;
  logic               enq_ok;
  logic               load;
  logic [CNT_W-1:0]   cp_offs;
  logic [CNT_W-1:0]   k_m1;
  logic [PTR_W-1:0]   wrap_offs;
  logic [PTR_W-1:0]   wrap_idx;
  ram_ctl_t           q_ctl;
  ram_ctl_t           s_ctl;
  logic [WORD_W-1:0]  q_rdata;
  logic [WORD_W-1:0]  s_rdata;

  assign cmd       = cmd_t'(in_tuser);
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign q_full    = (qfill_r >= CNT_W'(DEPTH));
  assign q_empty   = (qfill_r == '0);
  assign enq_ok    = in_fire && (cmd == CMD_ENQUEUE) && !q_full;
  assign cp_offs   = qfill_r - k_r - CNT_W'(1);
  assign k_m1      = k_r - CNT_W'(1);
  assign load      = (state_r == ST_SH_LD) && (!out_valid_r || out_tready);

  // operand select for the shared index adder
  always_comb begin
    wrap_offs = '0;
    if (state_r == ST_CP_RD) begin
      wrap_offs = cp_offs[PTR_W-1:0];
    end else begin
      case (cmd)
        CMD_ENQUEUE: wrap_offs = qfill_r[PTR_W-1:0];
        CMD_DEQUEUE: wrap_offs = PTR_W'(1);
        default:     wrap_offs = '0;
      endcase
    end
  end

  fss_wrap u_wrap (
    .base (qhead_r),
    .offs (wrap_offs),
    .idx  (wrap_idx)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (cmd == CMD_COPY && !q_empty) begin
            state_nxt = ST_CP_RD;
          end else if (cmd == CMD_SHOW && sfill_r != '0) begin
            state_nxt = ST_SH_RD;
          end
        end
      end
      ST_CP_RD: state_nxt = ST_CP_WR;
      ST_CP_WR: begin
        if (k_r + CNT_W'(1) == qfill_r) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_CP_RD;
        end
      end
      ST_SH_RD: state_nxt = ST_SH_LD;
      ST_SH_LD: begin
        if (load) begin
          state_nxt = (k_r == CNT_W'(1)) ? ST_IDLE : ST_SH_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    k_nxt         = k_r;
    qhead_nxt     = qhead_r;
    qfill_nxt     = qfill_r;
    sfill_nxt     = sfill_r;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;

    q_ctl.we      = enq_ok;
    q_ctl.waddr   = wrap_idx;
    q_ctl.re      = (state_r == ST_CP_RD);
    q_ctl.raddr   = wrap_idx;
    s_ctl.we      = (state_r == ST_CP_WR);
    s_ctl.waddr   = k_r[PTR_W-1:0];
    s_ctl.re      = (state_r == ST_SH_RD);
    s_ctl.raddr   = k_m1[PTR_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd)
            CMD_ENQUEUE: begin
              if (!q_full) begin
                qfill_nxt = qfill_r + CNT_W'(1);
              end
            end
            CMD_DEQUEUE: begin
              if (!q_empty) begin
                qhead_nxt = wrap_idx;
                qfill_nxt = qfill_r - CNT_W'(1);
              end
            end
            CMD_SHOW: k_nxt = sfill_r;
            CMD_COPY: begin
              k_nxt     = '0;
              sfill_nxt = qfill_r;
            end
            default: k_nxt = k_r;
          endcase
        end
      end
      ST_CP_WR: k_nxt = k_r + CNT_W'(1);
      ST_SH_LD: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = s_rdata;
          out_last_nxt  = (k_r == CNT_W'(1));
          k_nxt         = k_m1;
        end
      end
      default: k_nxt = k_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      qhead_r     <= '0;
      qfill_r     <= '0;
      sfill_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      qhead_r     <= qhead_nxt;
      qfill_r     <= qfill_nxt;
      sfill_r     <= sfill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

  fss_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH),
    .AW    (PTR_W)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_ctl.we),
    .waddr (q_ctl.waddr),
    .wdata (in_tdata),
    .re    (q_ctl.re),
    .raddr (q_ctl.raddr),
    .rdata (q_rdata)
  );

  fss_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH),
    .AW    (PTR_W)
  ) u_stack_ram (
    .clk   (clk),
    .we    (s_ctl.we),
    .waddr (s_ctl.waddr),
    .wdata (q_rdata),
    .re    (s_ctl.re),
    .raddr (s_ctl.raddr),
    .rdata (s_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tlast  = out_last_r;

  `FSS_ASSERT_IMP(a_fill_range, 1'b1, (qfill_r <= CNT_W'(DEPTH)) && (sfill_r <= CNT_W'(DEPTH)), "fill count beyond depth")
  `FSS_ASSERT_IMP(a_show_index, (state_r == ST_SH_RD) || (state_r == ST_SH_LD), (k_r != '0) && (k_r <= sfill_r), "show index outside stack")
  `FSS_ASSERT_IMP(a_copy_index, (state_r == ST_CP_RD) || (state_r == ST_CP_WR), k_r < qfill_r, "copy index outside queue")
  `FSS_ASSERT_NXT(a_enq_count, enq_ok, qfill_r == $past(qfill_r) + CNT_W'(1), "enqueue did not grow the queue")

endmodule

`default_nettype wire

// File: sv/fss_ram.sv
// ----------------------------------------------------------------------------
// fss_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module fss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/fss_wrap.sv
// ----------------------------------------------------------------------------
// fss_wrap
// shared circular index adder: (base + offs) modulo the queue depth
// ----------------------------------------------------------------------------
`default_nettype none

module fss_wrap (
  input  logic [fss_pkg::PTR_W-1:0] base,
  input  logic [fss_pkg::PTR_W-1:0] offs,
  output logic [fss_pkg::PTR_W-1:0] idx
);
  import fss_pkg::*;

  localparam logic [PTR_W:0] DEPTH_V = (PTR_W + 1)'(DEPTH);

  logic [PTR_W:0] sum;
  logic [PTR_W:0] wrapped;

  // both operands are below the depth, so one subtract is enough
  always_comb begin
    sum     = {1'b0, base} + {1'b0, offs};
    wrapped = (sum >= DEPTH_V) ? (sum - DEPTH_V) : sum;
    idx     = wrapped[PTR_W-1:0];
  end

endmodule

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench for fifo_with_stack_snapshot_unit
// drives random and directed enqueue / dequeue / copy / show commands,
// tracks queue and stack contents in a scoreboard and checks every show word
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import fss_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 4 * DEPTH + 16;

  // mirrors queue and stack, holds the show words still to come
  class snapshot_scoreboard;
    logic [WORD_W-1:0] queue_words [DEPTH];
    logic [PTR_W-1:0]  queue_head;
    logic [CNT_W-1:0]  queue_fill;
    logic [WORD_W-1:0] stack_words [DEPTH];
    logic [CNT_W-1:0]  stack_fill;
    logic [WORD_W-1:0] show_words [$];
    logic              show_lasts [$];
    int                errors;

    function new();
      queue_head = '0;
      queue_fill = '0;
      stack_fill = '0;
      errors     = 0;
    endfunction

    function int words_due();
      return show_words.size();
    endfunction

    function void note_command(cmd_t cmd, logic [WORD_W-1:0] value);
      int slot;
      case (cmd)
        CMD_ENQUEUE: begin
          if (queue_fill < DEPTH) begin
            slot = (int'(queue_head) + int'(queue_fill)) % DEPTH;
            queue_words[slot] = value;
            queue_fill++;
          end
        end
        CMD_DEQUEUE: begin
          if (queue_fill != 0) begin
            queue_head = PTR_W'((int'(queue_head) + 1) % DEPTH);
            queue_fill--;
          end
        end
        CMD_SHOW: begin
          for (int k = int'(stack_fill) - 1; k >= 0; k--) begin
            show_words.push_back(stack_words[k]);
            show_lasts.push_back(k == 0);
          end
        end
        CMD_COPY: begin
          // queue front ends up on top of the stack
          for (int k = 0; k < int'(queue_fill); k++) begin
            slot = (int'(queue_head) + int'(queue_fill) - 1 - k) % DEPTH;
            stack_words[k] = queue_words[slot];
          end
          stack_fill = queue_fill;
        end
        default: ;
      endcase
    endfunction

    function void check_word(logic [WORD_W-1:0] word, logic last);
      logic [WORD_W-1:0] exp_word;
      logic              exp_last;
      if (show_words.size() == 0) begin
        $display("%0t: unexpected output word, expected none, actual %h last %b",
                 $time, word, last);
        errors++;
        return;
      end
      exp_word = show_words.pop_front();
      exp_last = show_lasts.pop_front();
      if (word !== exp_word) begin
        $display("%0t: word mismatch, expected %h, actual %h", $time, exp_word, word);
        errors++;
      end
      if (last !== exp_last) begin
        $display("%0t: last mismatch, expected %b, actual %b", $time, exp_last, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [WORD_W-1:0] in_tdata;   // [31:0] value
  logic [CMD_W-1:0]  in_tuser;   // [1:0] cmd
  logic              out_tvalid;
  logic              out_tready;
  logic [WORD_W-1:0] out_tdata;  // [31:0] word
  logic              out_tlast;

  snapshot_scoreboard sb = new();
  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count;

  fifo_with_stack_snapshot_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  // receiver: sample transfers, then pick the next ready
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        sb.check_word(out_tdata, out_tlast);
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_command(input cmd_t cmd, input logic [WORD_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd, value);
  endtask

  // hold the sender off until every show word has been taken
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.words_due() != 0);
  endtask

  task automatic send_random(input int count, input int enq_w, input int deq_w,
                             input int show_w);
    int   pick;
    cmd_t cmd;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < enq_w)                       cmd = CMD_ENQUEUE;
      else if (pick < enq_w + deq_w)          cmd = CMD_DEQUEUE;
      else if (pick < enq_w + deq_w + show_w) cmd = CMD_SHOW;
      else                                    cmd = CMD_COPY;
      send_command(cmd, pick_word());
      if ($urandom_range(19) == 0)
        hold_until_drained();
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_tvalid     <= 1'b0;
    in_tdata      <= '0;
    in_tuser      <= CMD_ENQUEUE;
    send_idle_pct = 32;
    recv_idle_pct = 76;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue and empty stack
    send_command(CMD_SHOW, $urandom);
    send_command(CMD_DEQUEUE, $urandom);
    send_command(CMD_COPY, $urandom);
    send_command(CMD_SHOW, $urandom);
    // extremes of the word
    send_command(CMD_ENQUEUE, 32'h8000_0000);
    send_command(CMD_ENQUEUE, 32'h7fff_ffff);
    send_command(CMD_ENQUEUE, 32'h0000_0000);
    send_command(CMD_ENQUEUE, 32'hffff_ffff);
    send_command(CMD_COPY, $urandom);
    send_command(CMD_SHOW, $urandom);
    // show leaves the stack alone, dequeue leaves it too
    send_command(CMD_DEQUEUE, $urandom);
    send_command(CMD_SHOW, $urandom);
    send_command(CMD_COPY, $urandom);
    send_command(CMD_SHOW, $urandom);
    send_command(CMD_ENQUEUE, 32'h5555_5555);
    send_command(CMD_ENQUEUE, 32'haaaa_aaaa);
    repeat (3) send_command(CMD_DEQUEUE, $urandom);
    send_command(CMD_COPY, $urandom);
    send_command(CMD_SHOW, $urandom);
    // copy of an empty queue empties the stack
    repeat (2) send_command(CMD_DEQUEUE, $urandom);
    send_command(CMD_COPY, $urandom);
    send_command(CMD_SHOW, $urandom);
    hold_until_drained();

    send_random(30, 55, 15, 15);
    hold_until_drained();

    send_idle_pct = 76;
    recv_idle_pct = 32;
    // overfill the queue, then snapshot and show a full stack
    repeat (DEPTH + 2) send_command(CMD_ENQUEUE, pick_word());
    send_command(CMD_COPY, $urandom);
    send_command(CMD_SHOW, $urandom);
    send_random(20, 45, 20, 20);
    hold_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(10, 20, 45, 20);
    in_tvalid <= 1'b0;

    while (sb.words_due() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
